// ----- rtl/pcpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpfa_pkg
// Shared types, codes and constants of the per-CPU page free list allocator.
// ----------------------------------------------------------------------------
package pcpfa_pkg;

  localparam int unsigned CPU_COUNT_DEF     = 8;
  localparam int unsigned PAGE_CAPACITY_DEF = 1024;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_BYTES = 1 << PAGE_SHIFT;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PN_W       = ADDR_W - PAGE_SHIFT;
  localparam int unsigned CPU_IN_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ADDR_W-1:0] REGION_BASE_RST  = 32'd0;
  localparam logic [ADDR_W-1:0] REGION_LIMIT_RST = 32'd4194304;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_BASE  = 1'b0,
    REG_REGION_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OOM      = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic is_free;
    logic bad;
  } op_t;

  localparam int unsigned OP_W = $bits(op_t);

endpackage

// ----- rtl/per_cpu_page_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Per-CPU LIFO page free lists with stealing on an empty list.
// ----------------------------------------------------------------------------
// The request side takes one beat per cycle into a two-entry queue unless it
// is full. In the list engine a free, a rejected free and an out-of-memory
// allocation finish in ST_EXEC; a granting allocation adds ST_LINK for the
// registered read of the link memory. While a finished result waits in the
// result register the engine holds the next request, except for the link read
// of a granting allocation; a new result is loaded in the cycle the waiting one
// is taken. Lists are empty after reset with no clearing pass; fill them by
// freeing pages. Write region registers while idle; the block does not check.
module per_cpu_page_free_list_allocator #(
  parameter int unsigned CPU_COUNT     = pcpfa_pkg::CPU_COUNT_DEF,
  parameter int unsigned PAGE_CAPACITY = pcpfa_pkg::PAGE_CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pcpfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcpfa_pkg::ADDR_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [pcpfa_pkg::CPU_IN_W-1:0]    in_cpu_index,
  input  logic [pcpfa_pkg::ADDR_W-1:0]      in_page_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pcpfa_pkg::ADDR_W-1:0]      out_granted_address,
  output logic [1:0]                        out_status
);

  localparam int unsigned CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int unsigned IW    = $clog2(PAGE_CAPACITY);
  localparam int unsigned LW    = $clog2(PAGE_CAPACITY + 1);
  localparam int unsigned ENT_W = pcpfa_pkg::OP_W + CPU_W + IW;

  logic [ENT_W-1:0]            ent_data;
  logic [ENT_W-1:0]            q_data;
  logic [pcpfa_pkg::PN_W:0]    eff_pg;
  logic                        q_full, q_valid, q_pop, q_push;

  assign q_push   = in_valid && !q_full;
  assign in_stall = q_full;

  pcpfa_front #(
    .CPU_COUNT     (CPU_COUNT),
    .PAGE_CAPACITY (PAGE_CAPACITY),
    .CPU_W         (CPU_W),
    .IW            (IW),
    .ENT_W         (ENT_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_cpu_index    (in_cpu_index),
    .in_page_address (in_page_address),
    .ent_data        (ent_data),
    .eff_pg          (eff_pg)
  );

  pcpfa_fifo #(
    .W     (ENT_W),
    .DEPTH (pcpfa_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (ent_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_data (q_data)
  );

  pcpfa_back #(
    .CPU_COUNT     (CPU_COUNT),
    .PAGE_CAPACITY (PAGE_CAPACITY),
    .CPU_W         (CPU_W),
    .IW            (IW),
    .LW            (LW),
    .ENT_W         (ENT_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_data              (q_data),
    .q_pop               (q_pop),
    .eff_pg              (eff_pg),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

endmodule

// ----- rtl/pcpfa_front.sv -----
// ----------------------------------------------------------------------------
// pcpfa_front
// Holds the region registers and classifies each request beat: reduces the
// CPU number, checks a freed address and turns it into a page index.
// ----------------------------------------------------------------------------
module pcpfa_front #(
  parameter int unsigned CPU_COUNT     = pcpfa_pkg::CPU_COUNT_DEF,
  parameter int unsigned PAGE_CAPACITY = pcpfa_pkg::PAGE_CAPACITY_DEF,
  parameter int unsigned CPU_W         = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
  parameter int unsigned IW            = $clog2(PAGE_CAPACITY),
  parameter int unsigned ENT_W         = pcpfa_pkg::OP_W + CPU_W + IW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pcpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcpfa_pkg::ADDR_W-1:0]         cfg_wdata,
  input  logic                                 in_cmd,
  input  logic [pcpfa_pkg::CPU_IN_W-1:0]       in_cpu_index,
  input  logic [pcpfa_pkg::ADDR_W-1:0]         in_page_address,
  output logic [ENT_W-1:0]                     ent_data,
  output logic [pcpfa_pkg::PN_W:0]             eff_pg
);

  localparam int unsigned PS   = pcpfa_pkg::PAGE_SHIFT;
  localparam int unsigned PN_W = pcpfa_pkg::PN_W;

  logic [PN_W:0]                   eff_pg_r, eff_pg_nxt;
  logic [pcpfa_pkg::ADDR_W-1:0]    limit_r, limit_nxt;
  logic [3:0]                      cpu_v;
  logic [PN_W:0]                   apg;
  logic [PN_W:0]                   diff;
  logic                            aligned, ge_base, lt_limit, in_cap;
  pcpfa_pkg::op_t                  op;

  always_comb begin
    eff_pg_nxt = eff_pg_r;
    limit_nxt  = limit_r;
    if (cfg_we) begin
      unique case (pcpfa_pkg::cfg_reg_t'(cfg_index))
        pcpfa_pkg::REG_REGION_BASE: begin
          eff_pg_nxt = {1'b0, cfg_wdata[pcpfa_pkg::ADDR_W-1:PS]}
                       + (PN_W+1)'(|cfg_wdata[PS-1:0]);
        end
        pcpfa_pkg::REG_REGION_LIMIT: begin
          limit_nxt = cfg_wdata;
        end
        default: begin
          eff_pg_nxt = eff_pg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_pg_r <= (PN_W+1)'(pcpfa_pkg::REGION_BASE_RST >> PS);
      limit_r  <= pcpfa_pkg::REGION_LIMIT_RST;
    end else begin
      eff_pg_r <= eff_pg_nxt;
      limit_r  <= limit_nxt;
    end
  end

  always_comb begin
    cpu_v = {1'b0, in_cpu_index};
    for (int i = 0; i < 8; i++) begin
      if (int'(cpu_v) >= int'(CPU_COUNT)) begin
        cpu_v = cpu_v - 4'(CPU_COUNT);
      end
    end
  end

  always_comb begin
    apg      = {1'b0, in_page_address[pcpfa_pkg::ADDR_W-1:PS]};
    aligned  = (in_page_address[PS-1:0] == '0);
    ge_base  = (apg >= eff_pg_r);
    lt_limit = (in_page_address < limit_r);
    diff     = apg - eff_pg_r;
    in_cap   = ({1'b0, diff} < (PN_W+2)'(PAGE_CAPACITY));
    op.is_free = (pcpfa_pkg::cmd_t'(in_cmd) == pcpfa_pkg::CMD_FREE);
    op.bad     = !(aligned && ge_base && lt_limit && in_cap);
  end

  assign ent_data = {op, cpu_v[CPU_W-1:0], diff[IW-1:0]};
  assign eff_pg   = eff_pg_r;

endmodule

// ----- rtl/pcpfa_fifo.sv -----
// ----------------------------------------------------------------------------
// pcpfa_fifo
// Short request queue between the classifier and the list engine.
// ----------------------------------------------------------------------------
module pcpfa_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = pcpfa_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = entries_r[rd_ptr_r];

endmodule

// ----- rtl/pcpfa_back.sv -----
// ----------------------------------------------------------------------------
// pcpfa_back
// List engine: keeps the per-CPU head registers and the link memory, pushes
// freed pages, pops or steals on allocation, and holds the result register.
// ----------------------------------------------------------------------------
module pcpfa_back #(
  parameter int unsigned CPU_COUNT     = pcpfa_pkg::CPU_COUNT_DEF,
  parameter int unsigned PAGE_CAPACITY = pcpfa_pkg::PAGE_CAPACITY_DEF,
  parameter int unsigned CPU_W         = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
  parameter int unsigned IW            = $clog2(PAGE_CAPACITY),
  parameter int unsigned LW            = $clog2(PAGE_CAPACITY + 1),
  parameter int unsigned ENT_W         = pcpfa_pkg::OP_W + CPU_W + IW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  logic [ENT_W-1:0]                  q_data,
  output logic                              q_pop,
  input  logic [pcpfa_pkg::PN_W:0]          eff_pg,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pcpfa_pkg::ADDR_W-1:0]      out_granted_address,
  output logic [1:0]                        out_status
);

  localparam int unsigned PN_W = pcpfa_pkg::PN_W;

  typedef enum logic [1:0] {
    ST_EXEC = 2'b01,
    ST_LINK = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [LW-1:0]                 heads_r [CPU_COUNT];
  logic [LW-1:0]                 links_m [PAGE_CAPACITY];
  logic [LW-1:0]                 rdata_r;
  logic [CPU_W-1:0]              sel_r, sel_nxt;
  logic [IW-1:0]                 hidx_r, hidx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [pcpfa_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  pcpfa_pkg::status_t            out_status_r, out_status_nxt;

  pcpfa_pkg::op_t                e_op;
  logic [CPU_W-1:0]              e_cpu;
  logic [IW-1:0]                 e_idx;
  logic [CPU_COUNT-1:0]          nonempty;
  logic [CPU_W-1:0]              pri_sel, pick;
  logic [LW-1:0]                 pick_h;
  logic [IW-1:0]                 pick_idx;
  logic                          found;
  logic                          out_free;
  logic                          push_we, rd_en, link_done, res;
  logic [PN_W:0]                 gsum;

  always_comb begin
    e_op  = pcpfa_pkg::op_t'(q_data[ENT_W-1 -: pcpfa_pkg::OP_W]);
    e_cpu = q_data[IW +: CPU_W];
    e_idx = q_data[IW-1:0];
    for (int i = 0; i < int'(CPU_COUNT); i++) begin
      nonempty[i] = (heads_r[i] != '0);
    end
    pri_sel = '0;
    for (int i = int'(CPU_COUNT) - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pri_sel = CPU_W'(i);
      end
    end
    found    = |nonempty;
    pick     = nonempty[e_cpu] ? e_cpu : pri_sel;
    pick_h   = heads_r[pick];
    pick_idx = IW'(pick_h - LW'(1));
    gsum     = eff_pg + (PN_W+1)'(hidx_r);
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    hidx_nxt       = hidx_r;
    q_pop          = 1'b0;
    push_we        = 1'b0;
    rd_en          = 1'b0;
    link_done      = 1'b0;
    res            = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      ST_EXEC: begin
        if (q_valid) begin
          if (e_op.is_free) begin
            if (out_free) begin
              q_pop          = 1'b1;
              res            = 1'b1;
              push_we        = !e_op.bad;
              out_addr_nxt   = '0;
              out_status_nxt = e_op.bad ? pcpfa_pkg::STATUS_BAD_FREE
                                        : pcpfa_pkg::STATUS_OK;
            end
          end else if (found) begin
            q_pop     = 1'b1;
            rd_en     = 1'b1;
            sel_nxt   = pick;
            hidx_nxt  = pick_idx;
            state_nxt = ST_LINK;
          end else if (out_free) begin
            q_pop          = 1'b1;
            res            = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = pcpfa_pkg::STATUS_OOM;
          end
        end
      end
      ST_LINK: begin
        if (out_free) begin
          link_done      = 1'b1;
          res            = 1'b1;
          out_addr_nxt   = {gsum[PN_W-1:0], {pcpfa_pkg::PAGE_SHIFT{1'b0}}};
          out_status_nxt = pcpfa_pkg::STATUS_OK;
          state_nxt      = ST_EXEC;
        end
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase
    if (res) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      out_valid_r <= 1'b0;
      for (int i = 0; i < int'(CPU_COUNT); i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (push_we) begin
        heads_r[e_cpu] <= LW'(e_idx) + LW'(1);
      end else if (link_done) begin
        heads_r[sel_r] <= rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r        <= sel_nxt;
    hidx_r       <= hidx_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      links_m[e_idx] <= heads_r[e_cpu];
    end
    if (rd_en) begin
      rdata_r <= links_m[pick_idx];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

  a_link_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LINK && $past(state_r) != ST_LINK |-> $past(q_valid))
    else $error("link stage entered without a popped allocation");

  a_link_completes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LINK && out_free |=> state_r == ST_EXEC && out_valid_r)
    else $error("link stage did not deliver its result");

  a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != pcpfa_pkg::STATUS_OK |-> out_addr_r == '0)
    else $error("failed request carries an address");

endmodule
